// ----- hdl/aca_pkg.sv -----
// ----------------------------------------------------------------------------
// aca_pkg
// Shared widths, reset values, operation codes and types of the ARP cache.
// ----------------------------------------------------------------------------
package aca_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int LIFETIME_W  = 24;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int TIME_W      = 48;

    localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 24'd120000;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    typedef struct packed {
        logic any_match;
        logic any_free;
    } t_match;

endpackage

// ----- hdl/aca_match.sv -----
// ----------------------------------------------------------------------------
// aca_match
// Parallel address compare over all entries; picks the lowest valid match and
// the lowest free entry, both as one-hot vectors.
// ----------------------------------------------------------------------------
module aca_match
    import aca_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic [ENTRIES-1:0] i_valid,
    input  logic [IP_W-1:0]    i_entry_ip [ENTRIES],
    input  logic [IP_W-1:0]    i_ip,
    output logic [ENTRIES-1:0] o_match_oh,
    output logic [ENTRIES-1:0] o_free_oh,
    output t_match             o_flags
);

    localparam logic [ENTRIES-1:0] ONE = {{(ENTRIES-1){1'b0}}, 1'b1};

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_free;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = i_valid[i] && (i_entry_ip[i] == i_ip);
        end
    end

    assign w_free = ~i_valid;

    // isolate lowest set bit
    assign o_match_oh = w_match & (~w_match + ONE);
    assign o_free_oh  = w_free & (~w_free + ONE);

    assign o_flags.any_match = |w_match;
    assign o_flags.any_free  = |w_free;

endmodule

// ----- hdl/arp_cache_with_expiry_top.sv -----
// ----------------------------------------------------------------------------
// arp_cache_with_expiry_top
// Fully associative IPv4-to-MAC cache with per-entry expiry time.
// ----------------------------------------------------------------------------
// busy stays low: a command is taken in every cycle that start is high. Each
// command is registered, then gives one result word, shown on the result ports
// for exactly one cycle with o_done high. The receiver cannot stall, so it must
// take every word as it appears. The rate of one command per cycle is set by
// the single pass that compares all entries, updates the store and loads the
// result register; the expiry sum is formed as the command is registered.
// Valid marks are cleared by reset at once, so no clearing pass is needed. The
// user must write the lifetime register only while idle; the block does not enforce it.
module arp_cache_with_expiry_top
    import aca_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_func,
    input  logic [IP_W-1:0]       i_ip_address,
    input  logic [MAC_W-1:0]      i_mac_in,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_cfg_wr_en,
    input  logic [LIFETIME_W-1:0] i_cfg_wr_data,
    output logic                  o_done,
    output logic                  o_hit,
    output logic [MAC_W-1:0]      o_mac_out,
    output logic                  o_expired_dropped
);

    localparam logic [ENTRIES-1:0] ONE = {{(ENTRIES-1){1'b0}}, 1'b1};

    logic [LIFETIME_W-1:0] r_lifetime;

    logic                  r_go;
    t_func                 r_func;
    logic [IP_W-1:0]       r_ip;
    logic [MAC_W-1:0]      r_mac;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_exp;

    logic [ENTRIES-1:0]    r_valid;
    logic [ENTRIES-1:0]    n_valid;
    logic [IP_W-1:0]       r_entry_ip  [ENTRIES];
    logic [MAC_W-1:0]      r_entry_mac [ENTRIES];
    logic [TIME_W-1:0]     r_entry_exp [ENTRIES];

    logic                  r_done;
    logic                  r_hit;
    logic [MAC_W-1:0]      r_mac_out;
    logic                  r_dropped;
    logic                  n_hit;
    logic [MAC_W-1:0]      n_mac_out;
    logic                  n_dropped;

    logic [TIME_W:0]       w_sum;
    logic [TIME_W-1:0]     w_exp;
    logic [ENTRIES-1:0]    w_match_oh;
    logic [ENTRIES-1:0]    w_free_oh;
    t_match                w_flags;
    logic [ENTRIES-1:0]    w_wr_oh;
    logic [MAC_W-1:0]      w_sel_mac;
    logic [TIME_W-1:0]     w_sel_exp;
    logic                  w_insert;

    assign busy = 1'b0;

    // saturating expiry
    assign w_sum = {1'b0, i_now_ms} + {{(TIME_W+1-LIFETIME_W){1'b0}}, r_lifetime};
    assign w_exp = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    aca_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .i_valid    (r_valid),
        .i_entry_ip (r_entry_ip),
        .i_ip       (r_ip),
        .o_match_oh (w_match_oh),
        .o_free_oh  (w_free_oh),
        .o_flags    (w_flags)
    );

    assign w_insert = r_go && (r_func == FUNC_INSERT);

    always_comb begin
        priority if (w_flags.any_match) begin
            w_wr_oh = w_match_oh;
        end else if (w_flags.any_free) begin
            w_wr_oh = w_free_oh;
        end else begin
            w_wr_oh = ONE;
        end
    end

    always_comb begin
        w_sel_mac = '0;
        w_sel_exp = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_sel_mac = w_sel_mac | ({MAC_W{w_match_oh[i]}} & r_entry_mac[i]);
            w_sel_exp = w_sel_exp | ({TIME_W{w_match_oh[i]}} & r_entry_exp[i]);
        end
    end

    always_comb begin
        n_valid   = r_valid;
        n_hit     = 1'b0;
        n_mac_out = '0;
        n_dropped = 1'b0;
        if (r_go) begin
            unique case (r_func)
                FUNC_INSERT: begin
                    n_valid = r_valid | w_wr_oh;
                end
                FUNC_LOOKUP: begin
                    if (w_flags.any_match) begin
                        if (r_now > w_sel_exp) begin
                            n_valid   = r_valid & ~w_match_oh;
                            n_dropped = 1'b1;
                        end else begin
                            n_hit     = 1'b1;
                            n_mac_out = w_sel_mac;
                        end
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
            r_go       <= 1'b0;
            r_valid    <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lifetime <= i_cfg_wr_data;
            end
            r_go    <= start && !busy;
            r_valid <= n_valid;
            r_done  <= r_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_func <= t_func'(i_func);
            r_ip   <= i_ip_address;
            r_mac  <= i_mac_in;
            r_now  <= i_now_ms;
            r_exp  <= w_exp;
        end
        r_hit     <= n_hit;
        r_mac_out <= n_mac_out;
        r_dropped <= n_dropped;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_insert && w_wr_oh[i]) begin
                r_entry_ip[i]  <= r_ip;
                r_entry_mac[i] <= r_mac;
                r_entry_exp[i] <= r_exp;
            end
        end
    end

    assign o_done            = r_done;
    assign o_hit             = r_hit;
    assign o_mac_out         = r_mac_out;
    assign o_expired_dropped = r_dropped;

    a_match_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_oh))
        else $error("more than one entry selected as match");

    a_hit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_expired_dropped))
        else $error("hit and drop on the same word");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_mac_out == '0))
        else $error("mac_out not zero on miss");

    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_expired_dropped) |->
            ($countones(r_valid) < $countones($past(r_valid))))
        else $error("drop did not clear a valid mark");

    a_insert_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> (r_valid != '0) && ((r_valid & $past(r_valid)) == $past(r_valid)))
        else $error("insert lost a valid mark");

endmodule

// ----- sim/arp_cache_with_expiry_top_tb.sv -----
// ----------------------------------------------------------------------------
// arp_cache_with_expiry_top_tb
// Drives insert and lookup words into the ARP cache, with random gaps and
// several lifetime settings. Each word is predicted by a local copy of the
// cache, and every result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module arp_cache_with_expiry_top_tb;
    import aca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL  = 24;
    localparam int LIMIT = 200000;

    typedef struct packed {
        t_func             func;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
        logic             dropped;
    } t_reply;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    t_cmd                  drv_cmd     = '0;
    logic                  cfg_wr_en   = 1'b0;
    logic [LIFETIME_W-1:0] cfg_wr_data = '0;
    logic                  busy;
    logic                  o_done;
    logic                  o_hit;
    logic [MAC_W-1:0]      o_mac_out;
    logic                  o_expired_dropped;

    t_cmd   cmd_q[$];
    t_reply reply_q[$];
    int     fault_count = 0;
    int     words_sent  = 0;
    int     cycles      = 0;

    // cache copy used for prediction
    logic                  ent_valid [ENTRIES_DEF] = '{default: 1'b0};
    logic [IP_W-1:0]       ent_ip    [ENTRIES_DEF];
    logic [MAC_W-1:0]      ent_mac   [ENTRIES_DEF];
    logic [TIME_W-1:0]     ent_expiry[ENTRIES_DEF];
    logic [LIFETIME_W-1:0] lifetime_ms = LIFETIME_RESET;

    logic [IP_W-1:0]   ip_pool[POOL];
    logic [TIME_W-1:0] clock_ms = '0;

    arp_cache_with_expiry_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (drv_cmd.func),
        .i_ip_address     (drv_cmd.ip),
        .i_mac_in         (drv_cmd.mac),
        .i_now_ms         (drv_cmd.now),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .o_done           (o_done),
        .o_hit            (o_hit),
        .o_mac_out        (o_mac_out),
        .o_expired_dropped(o_expired_dropped)
    );

    always #4 clk = ~clk;

    function automatic t_reply arp_predict(input t_cmd c);
        t_reply r;
        int slot;
        logic [TIME_W:0] sum;
        r = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (slot < 0 && ent_valid[i] && ent_ip[i] == c.ip) slot = i;
        end
        if (c.func == FUNC_INSERT) begin
            for (int i = 0; i < ENTRIES_DEF; i++) begin
                if (slot < 0 && !ent_valid[i]) slot = i;
            end
            if (slot < 0) slot = 0;
            sum = {1'b0, c.now} + (TIME_W+1)'(lifetime_ms);
            ent_ip[slot]     = c.ip;
            ent_mac[slot]    = c.mac;
            ent_expiry[slot] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            ent_valid[slot]  = 1'b1;
        end else if (slot >= 0) begin
            if (c.now > ent_expiry[slot]) begin
                ent_valid[slot] = 1'b0;
                r.dropped = 1'b1;
            end else begin
                r.hit = 1'b1;
                r.mac = ent_mac[slot];
            end
        end
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    function automatic t_cmd random_cmd(input logic [LIFETIME_W-1:0] life);
        t_cmd c;
        int roll;
        logic [31:0] span;
        span = 32'(life / 8) + 32'd2;
        c.func = ($urandom_range(0, 1) != 0) ? FUNC_LOOKUP : FUNC_INSERT;
        c.ip   = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL-1)] : $urandom();
        c.mac  = rand48();
        clock_ms = clock_ms + TIME_W'($urandom_range(0, span));
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            c.now = clock_ms;
        end else if (roll < 92) begin
            c.now = clock_ms - TIME_W'($urandom_range(0, 4 * span));
        end else if (roll < 96) begin
            c.now = rand48();
        end else begin
            c.now = '1 - TIME_W'($urandom_range(0, 3));
        end
        return c;
    endfunction

    task automatic queue_cmd(input t_func f, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now);
        cmd_q.push_back('{func: f, ip: ip, mac: mac, now: now});
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) cmd_q.push_back(random_cmd(lifetime_ms));
    endtask

    task automatic settle();
        do @(posedge clk); while (cmd_q.size() != 0 || start || reply_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_lifetime(input logic [LIFETIME_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        lifetime_ms = v;
    endtask

    // driver: predict on acceptance, then load the next word or idle
    always @(posedge clk) begin : drive
        logic go;
        t_cmd nxt;
        go  = start;
        nxt = drv_cmd;
        if (rst_n) begin
            if (start && !busy) begin
                reply_q.push_back(arp_predict(drv_cmd));
                words_sent++;
                go = 1'b0;
            end
            if (!go && cmd_q.size() != 0 &&
                (($urandom_range(0, 99) >= 28) || (words_sent >= 250 && words_sent < 400))) begin
                nxt = cmd_q.pop_front();
                go  = 1'b1;
            end
            start   <= go;
            drv_cmd <= nxt;
        end
    end

    always @(posedge clk) begin : check
        t_reply want;
        if (rst_n && o_done === 1'b1) begin
            if (reply_q.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result word: hit=%b mac=%h dropped=%b",
                             o_hit, o_mac_out, o_expired_dropped);
                fault_count++;
            end else begin
                want = reply_q.pop_front();
                if (o_hit !== want.hit || o_mac_out !== want.mac ||
                    o_expired_dropped !== want.dropped) begin
                    if (fault_count < 10)
                        $display("mismatch: expected hit=%b mac=%h dropped=%b, got hit=%b mac=%h dropped=%b",
                                 want.hit, want.mac, want.dropped,
                                 o_hit, o_mac_out, o_expired_dropped);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int n;
        for (int i = 0; i < POOL; i++) ip_pool[i] = $urandom();
        ip_pool[0] = 32'h0000_0001;
        ip_pool[1] = 32'hFFFF_FFFE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty cache, boundary values, exact expiry, saturation, stale time, overwrite
        queue_cmd(FUNC_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 48'd0);
        queue_cmd(FUNC_INSERT, 32'h0, 48'h0, 48'd0);
        queue_cmd(FUNC_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0);
        queue_cmd(FUNC_LOOKUP, 32'h0, 48'h5555_5555_5555, 48'd120000);
        queue_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 48'd120000);
        queue_cmd(FUNC_LOOKUP, 32'h0, 48'h0, 48'd120001);
        queue_cmd(FUNC_LOOKUP, 32'h0, 48'h0, 48'd120001);
        queue_cmd(FUNC_INSERT, 32'hC0A8_0001, 48'h0200_0000_0001, 48'hFFFF_FFFF_FFFF);
        queue_cmd(FUNC_LOOKUP, 32'hC0A8_0001, 48'h0, 48'hFFFF_FFFF_FFFF);
        queue_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 48'd100);
        queue_cmd(FUNC_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 48'd5);
        queue_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 48'd5);
        queue_cmd(FUNC_LOOKUP, 32'hAAAA_5555, 48'h0, 48'hAAAA_AAAA_AAAA);
        clock_ms = 48'd1000;
        random_phase(115);
        settle();

        set_lifetime(24'd1);
        random_phase(115);
        settle();

        set_lifetime(24'hFF_FFFF);
        random_phase(115);
        settle();

        set_lifetime(24'd0);
        queue_cmd(FUNC_INSERT, ip_pool[0], rand48(), clock_ms);
        queue_cmd(FUNC_LOOKUP, ip_pool[0], 48'h0, clock_ms);
        queue_cmd(FUNC_LOOKUP, ip_pool[0], 48'h0, clock_ms + 48'd1);
        random_phase(115);
        settle();

        set_lifetime(LIFETIME_W'($urandom_range(2, 5000)));
        random_phase(115);
        settle();

        set_lifetime(LIFETIME_RESET);
        random_phase(115);

        do @(posedge clk); while (cmd_q.size() != 0 || start);
        n = 0;
        while (reply_q.size() != 0 && n < 64) begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
        fault_count += reply_q.size();
        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
